// ===== hw/rtl/cbml_pkg.sv =====
package cbml_pkg;

   localparam int OFFSET_WIDTH_DEFAULT = 40;
   localparam int COUNT_WIDTH          = 20;
   localparam int WINDOW_WIDTH         = 48;
   localparam int QUEUE_DEPTH          = 4;
   localparam int MIN_SPAN             = 130;
   localparam int MARK_LEN             = 49;

   localparam logic [WINDOW_WIDTH-1:0] HDR_MAGIC = 48'h3141_5926_5359;
   localparam logic [WINDOW_WIDTH-1:0] EOS_MAGIC = 48'h1772_4538_5090;

   localparam logic [COUNT_WIDTH-1:0] MAX_BLOCKS_RESET = 20'd200000;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX        = '1;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   typedef enum logic [1:0] {
      RES_BLOCK = 2'd0,
      RES_DONE  = 2'd1,
      RES_NONE  = 2'd2,
      RES_FULL  = 2'd3
   } result_kind_type;

   // control part of one queued job
   typedef struct packed {
      logic is_eos;
      logic is_marker;
      logic full;
      logic seen_marker;
   } entry_ctl_type;

endpackage

// ===== hw/rtl/cbml_if.sv =====
interface cbml_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface cbml_rsp_if #(
   parameter int OFFSET_WIDTH = cbml_pkg::OFFSET_WIDTH_DEFAULT
);
   logic                             valid;
   logic                             ready;
   logic [1:0]                       result_kind;
   logic [OFFSET_WIDTH-1:0]          block_start;
   logic [OFFSET_WIDTH-1:0]          block_end;
   logic [cbml_pkg::COUNT_WIDTH-1:0] block_count;

   modport source (output valid, output result_kind, output block_start,
                   output block_end, output block_count, input ready);
   modport sink   (input valid, input result_kind, input block_start,
                   input block_end, input block_count, output ready);
   modport mon    (input valid, input ready, input result_kind, input block_start,
                   input block_end, input block_count);
endinterface

// ===== hw/rtl/cbml_front.sv =====
module cbml_front #(
   parameter int OFFSET_WIDTH = cbml_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   cbml_req_if.sink                         req,
   input  logic [cbml_pkg::COUNT_WIDTH-1:0] max_blocks,
   input  logic                             q_full,
   output logic                             push,
   output cbml_pkg::entry_ctl_type          push_ctl,
   output logic [OFFSET_WIDTH-1:0]          push_pos,
   output logic [OFFSET_WIDTH-1:0]          push_start
);

   localparam int WW = cbml_pkg::WINDOW_WIDTH;

   logic [WW-1:0]                    window_ff;
   logic [OFFSET_WIDTH-1:0]          bit_count_ff;
   logic [OFFSET_WIDTH-1:0]          start_ff;
   logic [cbml_pkg::COUNT_WIDTH-1:0] marker_count_ff;
   logic                             full_ff;

   logic [WW+7:0] cat;
   logic          hit;
   logic [2:0]    hit_sel;
   logic          accept;
   logic          take_data;
   logic          at_cap;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign take_data = accept && (req.kind == cbml_pkg::KIND_DATA) && !full_ff;
   assign at_cap    = marker_count_ff >= max_blocks;
   assign cat       = {window_ff, req.data_byte};

   // eight window comparators, earliest bit position wins
   always_comb begin
      hit     = 1'b0;
      hit_sel = 3'd0;
      for (int k = 8; k >= 1; k--) begin
         if (cat[8-k +: WW] == cbml_pkg::HDR_MAGIC || cat[8-k +: WW] == cbml_pkg::EOS_MAGIC) begin
            hit     = 1'b1;
            hit_sel = 3'(k - 1);
         end
      end
   end

   assign push_pos   = bit_count_ff + OFFSET_WIDTH'(hit_sel) + OFFSET_WIDTH'(1);
   assign push_start = start_ff;
   assign push       = accept && ((req.kind == cbml_pkg::KIND_EOS) || (take_data && hit));

   always_comb begin
      push_ctl.is_eos      = (req.kind == cbml_pkg::KIND_EOS);
      push_ctl.is_marker   = (req.kind == cbml_pkg::KIND_DATA);
      push_ctl.full        = full_ff;
      push_ctl.seen_marker = (marker_count_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req.kind == cbml_pkg::KIND_EOS)) begin
         window_ff       <= '0;
         bit_count_ff    <= '0;
         start_ff        <= '0;
         marker_count_ff <= '0;
         full_ff         <= 1'b0;
      end else if (take_data) begin
         window_ff    <= cat[WW-1:0];
         bit_count_ff <= bit_count_ff + OFFSET_WIDTH'(8);
         if (hit && at_cap) begin
            full_ff <= 1'b1;
         end else if (hit) begin
            marker_count_ff <= marker_count_ff + 1'b1;
            start_ff        <= push_pos;
         end
      end
   end

endmodule

// ===== hw/rtl/cbml_queue.sv =====
module cbml_queue #(
   parameter int OFFSET_WIDTH = cbml_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cbml_pkg::entry_ctl_type push_ctl,
   input  logic [OFFSET_WIDTH-1:0] push_pos,
   input  logic [OFFSET_WIDTH-1:0] push_start,
   output logic                    full,
   input  logic                    pop,
   output logic                    q_valid,
   output cbml_pkg::entry_ctl_type q_ctl,
   output logic [OFFSET_WIDTH-1:0] q_pos,
   output logic [OFFSET_WIDTH-1:0] q_start
);

   localparam int DEPTH = cbml_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   cbml_pkg::entry_ctl_type ctl_ff   [DEPTH];
   logic [OFFSET_WIDTH-1:0] pos_ff   [DEPTH];
   logic [OFFSET_WIDTH-1:0] start_ff [DEPTH];
   logic [PW-1:0]           wr_ptr_ff;
   logic [PW-1:0]           rd_ptr_ff;
   logic [PW:0]             count_ff;

   assign full    = (count_ff == (PW+1)'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_ctl   = ctl_ff[rd_ptr_ff];
   assign q_pos   = pos_ff[rd_ptr_ff];
   assign q_start = start_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]   <= push_ctl;
         pos_ff[wr_ptr_ff]   <= push_pos;
         start_ff[wr_ptr_ff] <= push_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/cbml_back.sv =====
module cbml_back #(
   parameter int OFFSET_WIDTH = cbml_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  cbml_pkg::entry_ctl_type q_ctl,
   input  logic [OFFSET_WIDTH-1:0] q_pos,
   input  logic [OFFSET_WIDTH-1:0] q_start,
   output logic                    pop,
   cbml_rsp_if.source              rsp
);

   localparam int CW = cbml_pkg::COUNT_WIDTH;

   // stage a: block end
   logic                    a_valid_ff;
   cbml_pkg::entry_ctl_type a_ctl_ff;
   logic [OFFSET_WIDTH-1:0] a_end_ff;
   logic [OFFSET_WIDTH-1:0] a_start_ff;
   logic [OFFSET_WIDTH-1:0] end_in;

   // output stage
   logic                    rsp_valid_ff;
   logic [1:0]              kind_ff;
   logic [OFFSET_WIDTH-1:0] start_out_ff;
   logic [OFFSET_WIDTH-1:0] end_out_ff;
   logic [CW-1:0]           count_out_ff;
   logic [CW-1:0]           reported_ff;

   logic                    out_free;
   logic                    advance;
   logic [OFFSET_WIDTH:0]   diff;
   logic                    qualify;
   logic [CW-1:0]           reported_in;
   cbml_pkg::result_kind_type eos_kind;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign advance  = a_valid_ff && out_free;
   assign pop      = q_valid && (!a_valid_ff || out_free);

   assign end_in = (q_pos > OFFSET_WIDTH'(cbml_pkg::MARK_LEN))
                   ? q_pos - OFFSET_WIDTH'(cbml_pkg::MARK_LEN) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (pop) begin
         a_valid_ff <= 1'b1;
      end else if (out_free) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_ctl_ff   <= q_ctl;
         a_end_ff   <= end_in;
         a_start_ff <= q_start;
      end
   end

   // borrow out of the top bit means end lies before start
   assign diff    = {1'b0, a_end_ff} - {1'b0, a_start_ff};
   assign qualify = a_ctl_ff.is_marker && a_ctl_ff.seen_marker && !diff[OFFSET_WIDTH]
                    && (diff[OFFSET_WIDTH-1:0] >= OFFSET_WIDTH'(cbml_pkg::MIN_SPAN));
   assign reported_in = (reported_ff == cbml_pkg::COUNT_MAX) ? reported_ff
                                                             : reported_ff + 1'b1;

   always_comb begin
      if (a_ctl_ff.full) begin
         eos_kind = cbml_pkg::RES_FULL;
      end else if (reported_ff == '0) begin
         eos_kind = cbml_pkg::RES_NONE;
      end else begin
         eos_kind = cbml_pkg::RES_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         reported_ff  <= '0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && (a_ctl_ff.is_eos || qualify);
         if (advance && a_ctl_ff.is_eos) begin
            reported_ff <= '0;
         end else if (advance && qualify) begin
            reported_ff <= reported_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (a_ctl_ff.is_eos) begin
            kind_ff      <= eos_kind;
            start_out_ff <= '0;
            end_out_ff   <= '0;
            count_out_ff <= reported_ff;
         end else begin
            kind_ff      <= cbml_pkg::RES_BLOCK;
            start_out_ff <= a_start_ff;
            end_out_ff   <= a_end_ff;
            count_out_ff <= reported_in;
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_kind = kind_ff;
   assign rsp.block_start = start_out_ff;
   assign rsp.block_end   = end_out_ff;
   assign rsp.block_count = count_out_ff;

endmodule

// ===== hw/rtl/compressed_block_marker_locator_top.sv =====
// channel   port      dir  fields
// request   req_chan  in   kind (1), data_byte (8)
// response  rsp_chan  out  result_kind (2), block_start, block_end (OFFSET_WIDTH),
//                          block_count (20)
// config    csr_*     in   csr_we, csr_wdata = max_blocks (20)
//
// one transaction per cycle sustained while the queue has room: eight parallel
// window comparators scan a byte; a response passes the queue entry (written at
// the accepting edge), then end calc, then the output register
// a 4-entry queue between scanner and reporter absorbs response stalls; req ready
// drops only when that queue is full
// synchronous active-high reset clears control state, max_blocks returns to 200000
module compressed_block_marker_locator_top #(
   parameter int OFFSET_WIDTH = cbml_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   cbml_req_if.sink                         req_chan,
   cbml_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [cbml_pkg::COUNT_WIDTH-1:0] csr_wdata
);

   // capacity of the caller's block list
   logic [cbml_pkg::COUNT_WIDTH-1:0] max_blocks_ff;

   // scanner to queue
   logic                    push;
   cbml_pkg::entry_ctl_type push_ctl;
   logic [OFFSET_WIDTH-1:0] push_pos;
   logic [OFFSET_WIDTH-1:0] push_start;
   logic                    q_full;

   // queue to reporter
   logic                    pop;
   logic                    q_valid;
   cbml_pkg::entry_ctl_type q_ctl;
   logic [OFFSET_WIDTH-1:0] q_pos;
   logic [OFFSET_WIDTH-1:0] q_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_blocks_ff <= cbml_pkg::MAX_BLOCKS_RESET;
      end else if (csr_we) begin
         max_blocks_ff <= csr_wdata;
      end
   end

   // front: bit window, bit counter, marker count and full state
   cbml_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .max_blocks (max_blocks_ff),
      .q_full     (q_full),
      .push       (push),
      .push_ctl   (push_ctl),
      .push_pos   (push_pos),
      .push_start (push_start)
   );

   // only markers and end-of-stream transactions are queued
   cbml_queue #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ctl   (push_ctl),
      .push_pos   (push_pos),
      .push_start (push_start),
      .full       (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_ctl      (q_ctl),
      .q_pos      (q_pos),
      .q_start    (q_start)
   );

   // back: span check, reported count, result formatting
   cbml_back #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ctl   (q_ctl),
      .q_pos   (q_pos),
      .q_start (q_start),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

endmodule

// ===== hw/rtl/cbml_checker.sv =====
module cbml_checker (
   input logic        clock,
   input logic        reset,
   cbml_rsp_if.source rsp
);

   // a held response does not vanish
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid)
      else $error("response dropped while stalled");

   // reset leaves no response pending
   assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("response valid right after reset");

   // a reported block spans at least the minimum length
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_kind == cbml_pkg::RES_BLOCK |->
         rsp.block_end >= rsp.block_start &&
         (rsp.block_end - rsp.block_start) >= cbml_pkg::MIN_SPAN)
      else $error("reported block too short");

   // end-of-stream responses carry no offsets
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_kind != cbml_pkg::RES_BLOCK |->
         rsp.block_start == '0 && rsp.block_end == '0)
      else $error("offsets in end-of-stream response");

   // a block result always counts itself
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_kind == cbml_pkg::RES_BLOCK |-> rsp.block_count != '0)
      else $error("block result with zero count");

endmodule

bind compressed_block_marker_locator_top cbml_checker u_cbml_checker (
   .clock (clock),
   .reset (reset),
   .rsp   (rsp_chan)
);
